// ----- sv/ptt_pkg.sv -----
// ptt_pkg: shared types, codes and sizing constants for the periodic task timer table
// used by every module of the block; depends on nothing else
package ptt_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int MAX_RESULTS   = 8;
   localparam int CMDQ_DEPTH    = 2;
   localparam int RSPQ_DEPTH    = 4;

   // request commands
   localparam logic [1:0] CMD_TICK         = 2'd0;
   localparam logic [1:0] CMD_ADD_PERIODIC = 2'd1;
   localparam logic [1:0] CMD_ADD_ONESHOT  = 2'd2;
   localparam logic [1:0] CMD_DISPATCH     = 2'd3;

   // response kinds
   localparam logic [1:0] KIND_TICK     = 2'd0;
   localparam logic [1:0] KIND_ADD      = 2'd1;
   localparam logic [1:0] KIND_DISPATCH = 2'd2;
   localparam logic [1:0] KIND_NONE     = 2'd3;

   // classified operations handed from front to back
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_ADD      = 2'd1;
   localparam logic [1:0] OP_DISPATCH = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  task_id;
      logic [15:0] period;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       add_accepted;
      logic [2:0] slot_number;
      logic [7:0] dispatched_task;
      logic [7:0] pending_left;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]  op_code;
      logic        periodic;
      logic [7:0]  task_id;
      logic [15:0] period;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } op_chan_type;

   typedef struct packed {
      logic [7:0]  task_id;
      logic [15:0] interval;
      logic [15:0] countdown;
      logic [7:0]  ready;
   } slot_type;

endpackage

// ----- sv/periodic_task_timer_table_unit.sv -----
// Periodic task timer table, top level.
// Request side is a queue: an item is taken when push is high and full is low.
// Commands: tick, add periodic task, add one-shot task, dispatch ready tasks.
// Response side is a queue: the oldest beat shows on rsp_item while empty is low
// and leaves when pop is high. Each request ends with a beat that has last set.
// A two-entry command queue feeds the execution engine, so new requests are
// taken while earlier work or responses are still waiting.
// Add: in its add state the engine writes the slot and queues the response beat.
// Tick and dispatch: the engine walks the used slots one per cycle through the
// single read port of the slot memory, except where a dispatch hit waits for room;
// a dispatch reports at most eight ready slots, lowest first.
// Reset empties both queues and sets the fill count to zero; the slot memory
// needs no clearing since slots at or above the fill count are never read.
// When the receiver stalls, the four-entry response queue fills and the walk
// pauses on its next dispatch hit until pop frees a place.
// Depends on ptt_pkg, ptt_front, ptt_back and ptt_rsp_queue.
module periodic_task_timer_table_unit #(
   parameter int SLOTS = ptt_pkg::SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ptt_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output ptt_pkg::rsp_type rsp_item
);

   ptt_pkg::op_chan_type op_chan;
   logic                 op_take;
   logic                 back_push;
   ptt_pkg::rsp_type     back_item;
   logic                 rspq_full;

   ptt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_item (req_item),
      .op_chan  (op_chan),
      .op_take  (op_take)
   );

   ptt_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op_chan  (op_chan),
      .op_take  (op_take),
      .rsp_room (!rspq_full),
      .rsp_push (back_push),
      .rsp_item (back_item)
   );

   ptt_rsp_queue u_rsp_queue (
      .clock    (clock),
      .reset    (reset),
      .in_push  (back_push),
      .in_item  (back_item),
      .full     (rspq_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

`ifndef SYNTHESIS
   a_rsp_no_overflow: assert property (@(posedge clock) disable iff (reset)
      back_push |-> !rspq_full)
      else $error("engine pushed a response beat into a full queue");

   a_take_needs_op: assert property (@(posedge clock) disable iff (reset)
      op_take |-> op_chan.valid)
      else $error("engine took an operation from an empty command queue");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");
`endif

endmodule

// ----- sv/ptt_front.sv -----
// ptt_front: accepts request beats, classifies the command and queues the operation
// depends on ptt_pkg
module ptt_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  ptt_pkg::req_type     req_item,
   output ptt_pkg::op_chan_type op_chan,
   input  logic                 op_take
);

   localparam int DEPTH = ptt_pkg::CMDQ_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   ptt_pkg::op_type q_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   ptt_pkg::op_type op_dec;
   logic            do_push, do_pop;

   always_comb begin
      op_dec          = '0;
      op_dec.task_id  = req_item.task_id;
      op_dec.period   = req_item.period;
      case (req_item.command)
         ptt_pkg::CMD_TICK: begin
            op_dec.op_code = ptt_pkg::OP_TICK;
         end
         ptt_pkg::CMD_ADD_PERIODIC: begin
            op_dec.op_code  = ptt_pkg::OP_ADD;
            op_dec.periodic = 1'b1;
         end
         ptt_pkg::CMD_ADD_ONESHOT: begin
            op_dec.op_code = ptt_pkg::OP_ADD;
         end
         ptt_pkg::CMD_DISPATCH: begin
            op_dec.op_code = ptt_pkg::OP_DISPATCH;
         end
         default: begin
            op_dec.op_code = ptt_pkg::OP_TICK;
         end
      endcase
   end

   assign full          = (count_ff == CW'(DEPTH));
   assign do_push       = push && !full;
   assign do_pop        = op_take && (count_ff != '0);
   assign op_chan.valid = (count_ff != '0);
   assign op_chan.op    = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= op_dec;
      end
   end

endmodule

// ----- sv/ptt_back.sv -----
// ptt_back: slot memory and the engine that carries out tick, add and dispatch
// depends on ptt_pkg; walks the used slots one per cycle through one read port, unless a dispatch hit waits
module ptt_back #(
   parameter int SLOTS = ptt_pkg::SLOTS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  ptt_pkg::op_chan_type op_chan,
   output logic                 op_take,
   input  logic                 rsp_room,
   output logic                 rsp_push,
   output ptt_pkg::rsp_type     rsp_item
);

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int EW = $clog2(ptt_pkg::MAX_RESULTS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ADD    = 2'd1;
   localparam logic [1:0] ST_WALK   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   ptt_pkg::slot_type slot_mem [SLOTS];

   logic [1:0]        state_ff, state_in;
   ptt_pkg::op_type   op_ff, op_in;
   logic [CW-1:0]     used_ff, used_in;
   logic [CW-1:0]     issue_ff, issue_in;
   logic [SW-1:0]     rd_idx_ff, rd_idx_in;
   logic              rd_valid_ff, rd_valid_in;
   ptt_pkg::slot_type rd_data_ff;
   logic [EW-1:0]     emitted_ff, emitted_in;
   logic              hold_valid_ff, hold_valid_in;
   ptt_pkg::rsp_type  hold_ff, hold_in;

   logic              rd_en, wr_en;
   logic [SW-1:0]     rd_addr, wr_addr;
   ptt_pkg::slot_type wr_data, upd;
   ptt_pkg::rsp_type  result;
   logic              fires, exec_fire;

   assign rd_addr = issue_ff[SW-1:0];

   // per-slot update of the entry sitting in the read register
   always_comb begin
      upd    = rd_data_ff;
      result = '0;
      fires  = 1'b0;
      if (op_ff.op_code == ptt_pkg::OP_DISPATCH) begin
         if (rd_data_ff.ready != '0 && emitted_ff < EW'(ptt_pkg::MAX_RESULTS)) begin
            fires     = 1'b1;
            upd.ready = rd_data_ff.ready - 8'd1;
            // finished one-shot clears its slot entry; the fill count stays as it is
            if (upd.ready == '0 && rd_data_ff.interval == '0) begin
               upd.task_id   = '0;
               upd.countdown = '0;
               upd.interval  = '0;
            end
            result.kind            = ptt_pkg::KIND_DISPATCH;
            result.slot_number     = 3'(rd_idx_ff);
            result.dispatched_task = rd_data_ff.task_id;
            result.pending_left    = upd.ready;
         end
      end else if (rd_data_ff.task_id != '0 && rd_data_ff.countdown != '0) begin
         upd.countdown = rd_data_ff.countdown - 16'd1;
         if (upd.countdown == '0) begin
            if (rd_data_ff.ready != 8'hFF) begin
               upd.ready = rd_data_ff.ready + 8'd1;
            end
            if (rd_data_ff.interval != '0) begin
               upd.countdown = rd_data_ff.interval;
            end
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      used_in       = used_ff;
      issue_in      = issue_ff;
      rd_idx_in     = rd_idx_ff;
      rd_valid_in   = rd_valid_ff;
      emitted_in    = emitted_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      op_take       = 1'b0;
      rsp_push      = 1'b0;
      rsp_item      = '0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = rd_idx_ff;
      wr_data       = upd;
      exec_fire     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (op_chan.valid) begin
               op_take       = 1'b1;
               op_in         = op_chan.op;
               issue_in      = '0;
               rd_valid_in   = 1'b0;
               emitted_in    = '0;
               hold_valid_in = 1'b0;
               state_in      = (op_chan.op.op_code == ptt_pkg::OP_ADD) ? ST_ADD : ST_WALK;
            end
         end
         ST_ADD: begin
            if (rsp_room) begin
               rsp_push      = 1'b1;
               rsp_item.kind = ptt_pkg::KIND_ADD;
               rsp_item.last = 1'b1;
               if (used_ff < CW'(SLOTS)) begin
                  wr_en                 = 1'b1;
                  wr_addr               = used_ff[SW-1:0];
                  wr_data.task_id       = op_ff.task_id;
                  wr_data.interval      = op_ff.periodic ? op_ff.period : '0;
                  wr_data.countdown     = op_ff.period;
                  wr_data.ready         = '0;
                  used_in               = used_ff + 1'b1;
                  rsp_item.add_accepted = 1'b1;
                  rsp_item.slot_number  = 3'(used_ff[SW-1:0]);
               end
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            // a dispatch hit only waits when the held beat must go out first and the response queue is full
            exec_fire = rd_valid_ff && (!(fires && hold_valid_ff) || rsp_room);
            if (exec_fire) begin
               wr_en = 1'b1;
               if (fires) begin
                  if (hold_valid_ff) begin
                     rsp_push = 1'b1;
                     rsp_item = hold_ff;
                  end
                  hold_in       = result;
                  hold_valid_in = 1'b1;
                  emitted_in    = emitted_ff + 1'b1;
               end
            end
            if (!rd_valid_ff || exec_fire) begin
               if (issue_ff < used_ff) begin
                  rd_en       = 1'b1;
                  rd_idx_in   = issue_ff[SW-1:0];
                  issue_in    = issue_ff + 1'b1;
                  rd_valid_in = 1'b1;
               end else begin
                  rd_valid_in = 1'b0;
                  state_in    = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (rsp_room) begin
               rsp_push = 1'b1;
               if (op_ff.op_code == ptt_pkg::OP_DISPATCH) begin
                  if (hold_valid_ff) begin
                     rsp_item = hold_ff;
                  end else begin
                     rsp_item.kind = ptt_pkg::KIND_NONE;
                  end
               end else begin
                  rsp_item.kind = ptt_pkg::KIND_TICK;
               end
               rsp_item.last = 1'b1;
               hold_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= '0;
         issue_ff      <= '0;
         rd_valid_ff   <= 1'b0;
         emitted_ff    <= '0;
         hold_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         issue_ff      <= issue_in;
         rd_valid_ff   <= rd_valid_in;
         emitted_ff    <= emitted_in;
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      rd_idx_ff <= rd_idx_in;
      hold_ff   <= hold_in;
   end

   // slot memory: slots at or above the fill count are never read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

endmodule

// ----- sv/ptt_rsp_queue.sv -----
// ptt_rsp_queue: small response queue between the back engine and the rsp port
// depends on ptt_pkg
module ptt_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_push,
   input  ptt_pkg::rsp_type in_item,
   output logic             full,
   output logic             empty,
   input  logic             pop,
   output ptt_pkg::rsp_type rsp_item
);

   localparam int DEPTH = ptt_pkg::RSPQ_DEPTH;
   localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);

   ptt_pkg::rsp_type q_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = in_push && !full;
   assign do_pop   = pop && !empty;
   assign rsp_item = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule
